FILE: rtl/core/pcfs_pkg.sv
// Shared types, register indexes and the sweep helper function for the pulse channel.
`timescale 1ns / 1ps

package pcfs_pkg;

    localparam int unsigned FREQ_W = 11;
    localparam int unsigned TIMER_W = 14;
    localparam int unsigned ADDR_W = 5;
    localparam int unsigned DATA_W = 32;

    localparam logic [2:0] REG_SWEEP_PACE   = 3'd0;
    localparam logic [2:0] REG_SWEEP_NEGATE = 3'd1;
    localparam logic [2:0] REG_SWEEP_SHIFT  = 3'd2;
    localparam logic [2:0] REG_DUTY_PATTERN = 3'd3;
    localparam logic [2:0] REG_VOLUME       = 3'd4;
    localparam logic [2:0] REG_DAC_ENABLE   = 3'd5;
    localparam logic [2:0] REG_FREQUENCY    = 3'd6;

    localparam logic [11:0] FREQ_SPAN = 12'd2048;
    localparam logic [3:0] SWEEP_DEFAULT_RELOAD = 4'd8;
    localparam logic [1:0] SWEEP_FRAME_STEP = 2'd2;

    localparam logic [7:0] DUTY_TABLE [4] = '{8'hFE, 8'h7E, 8'h78, 8'h81};

    typedef struct packed {
        logic       opcode;
        logic       frame_event;
        logic [2:0] frame_step;
    } t_in_item;

    typedef struct packed {
        logic signed [4:0]  level;
        logic               channel_on;
        logic [FREQ_W-1:0]  current_frequency;
    } t_out_item;

    typedef struct packed {
        logic [2:0]        sweep_pace;
        logic              sweep_negate;
        logic [2:0]        sweep_shift;
        logic [1:0]        duty_pattern;
        logic [3:0]        volume;
        logic              dac_enable;
        logic [FREQ_W-1:0] frequency_setting;
    } t_cfg;

    // Next sweep value at 12 bits; bit 11 set means the result exceeds 2047.
    function automatic logic [FREQ_W:0] sweep_calc(
        input logic [FREQ_W-1:0] shadow,
        input logic              negate,
        input logic [2:0]        shift
    );
        logic [FREQ_W:0] base;
        logic [FREQ_W:0] delta;
        base = {1'b0, shadow};
        delta = base >> shift;
        sweep_calc = negate ? (base - delta) : (base + delta);
    endfunction

endpackage

FILE: rtl/core/pulse_channel_with_frequency_sweep.sv
// Top level of the square-wave sound channel with frequency sweep.
`timescale 1ns / 1ps

// Square-wave channel with frequency sweep. Every accepted item (one tick or one trigger)
// produces exactly one result, which appears in the result register on the clock after
// acceptance. The channel takes one item per clock: all state updates for an item are a
// single pass of logic into the state and result registers, and a new item is taken
// while the previous result is still waiting as long as the output is not stalled.
// Configuration registers sit at byte addresses 4*i and apply to the next item taken.
module pulse_channel_with_frequency_sweep (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  pcfs_pkg::t_in_item           i_in_item,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output pcfs_pkg::t_out_item          o_out_item,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [pcfs_pkg::ADDR_W-1:0]  paddr,
    input  logic [pcfs_pkg::DATA_W-1:0]  pwdata,
    output logic [pcfs_pkg::DATA_W-1:0]  prdata,
    output logic                         pready
);
    import pcfs_pkg::*;

    t_cfg              cfg;
    logic              in_accept;
    logic [FREQ_W-1:0] freq;
    logic [FREQ_W-1:0] next_freq;
    logic              next_enabled;
    logic signed [4:0] next_level;
    logic              r_out_valid;
    t_out_item         r_out_item;

    assign o_in_stall = r_out_valid && i_out_stall;
    assign in_accept = i_in_valid && !o_in_stall;

    pcfs_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    pcfs_sweep u_sweep (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (in_accept),
        .i_item         (i_in_item),
        .i_cfg          (cfg),
        .o_freq         (freq),
        .o_next_freq    (next_freq),
        .o_next_enabled (next_enabled)
    );

    pcfs_tone u_tone (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (in_accept),
        .i_item       (i_in_item),
        .i_cfg        (cfg),
        .i_freq       (next_freq),
        .o_next_level (next_level)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out_item.level <= next_level;
            r_out_item.channel_on <= next_enabled;
            r_out_item.current_frequency <= next_freq;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item = r_out_item;

`ifndef ASSERT_OFF
    a_accept_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> o_out_valid)
        else $error("accepted item produced no result");

    a_trigger_loads_freq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept && i_in_item.opcode
        |=> o_out_item.current_frequency == $past(cfg.frequency_setting))
        else $error("trigger did not load the frequency setting");

    a_no_sweep_keeps_freq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept && !i_in_item.opcode
        && !(i_in_item.frame_event && i_in_item.frame_step[1:0] == SWEEP_FRAME_STEP)
        |=> o_out_item.current_frequency == $past(freq))
        else $error("frequency changed without a sweep step");

    a_dac_off_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept && !cfg.dac_enable |=> o_out_item.level == 5'sd0)
        else $error("nonzero level while the DAC is off");
`endif

endmodule

FILE: rtl/core/pcfs_cfg.sv
// Configuration register file behind the APB-style port.
`timescale 1ns / 1ps

module pcfs_cfg (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [pcfs_pkg::ADDR_W-1:0]  paddr,
    input  logic [pcfs_pkg::DATA_W-1:0]  pwdata,
    output logic [pcfs_pkg::DATA_W-1:0]  prdata,
    output logic                         pready,
    output pcfs_pkg::t_cfg               o_cfg
);
    import pcfs_pkg::*;

    t_cfg       r_cfg;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign pready = 1'b1;
    assign wr_en = psel && penable && pwrite;
    assign reg_idx = paddr[4:2];
    assign o_cfg = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (wr_en) begin
            case (reg_idx)
                REG_SWEEP_PACE:   r_cfg.sweep_pace <= pwdata[2:0];
                REG_SWEEP_NEGATE: r_cfg.sweep_negate <= pwdata[0];
                REG_SWEEP_SHIFT:  r_cfg.sweep_shift <= pwdata[2:0];
                REG_DUTY_PATTERN: r_cfg.duty_pattern <= pwdata[1:0];
                REG_VOLUME:       r_cfg.volume <= pwdata[3:0];
                REG_DAC_ENABLE:   r_cfg.dac_enable <= pwdata[0];
                REG_FREQUENCY:    r_cfg.frequency_setting <= pwdata[FREQ_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        case (reg_idx)
            REG_SWEEP_PACE:   prdata[2:0] = r_cfg.sweep_pace;
            REG_SWEEP_NEGATE: prdata[0] = r_cfg.sweep_negate;
            REG_SWEEP_SHIFT:  prdata[2:0] = r_cfg.sweep_shift;
            REG_DUTY_PATTERN: prdata[1:0] = r_cfg.duty_pattern;
            REG_VOLUME:       prdata[3:0] = r_cfg.volume;
            REG_DAC_ENABLE:   prdata[0] = r_cfg.dac_enable;
            REG_FREQUENCY:    prdata[FREQ_W-1:0] = r_cfg.frequency_setting;
            default:          prdata = '0;
        endcase
    end

endmodule

FILE: rtl/core/pcfs_sweep.sv
// Frequency sweep unit, trigger handling and channel enable state.
`timescale 1ns / 1ps

module pcfs_sweep (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_accept,
    input  pcfs_pkg::t_in_item           i_item,
    input  pcfs_pkg::t_cfg               i_cfg,
    output logic [pcfs_pkg::FREQ_W-1:0]  o_freq,
    output logic [pcfs_pkg::FREQ_W-1:0]  o_next_freq,
    output logic                         o_next_enabled
);
    import pcfs_pkg::*;

    logic [FREQ_W-1:0] r_freq, n_freq;
    logic [FREQ_W-1:0] r_shadow, n_shadow;
    logic [3:0]        r_count, n_count;
    logic              r_sweep_active, n_sweep_active;
    logic              r_enabled, n_enabled;

    logic [FREQ_W:0]   trig_calc;
    logic [FREQ_W:0]   step_calc;
    logic [FREQ_W:0]   check_calc;
    logic [3:0]        reload;
    logic [3:0]        count_dec;
    logic              sweep_frame;

    assign trig_calc = sweep_calc(i_cfg.frequency_setting, i_cfg.sweep_negate,
                                  i_cfg.sweep_shift);
    assign step_calc = sweep_calc(r_shadow, i_cfg.sweep_negate, i_cfg.sweep_shift);
    assign check_calc = sweep_calc(step_calc[FREQ_W-1:0], i_cfg.sweep_negate,
                                   i_cfg.sweep_shift);
    assign reload = (i_cfg.sweep_pace != 3'd0) ? {1'b0, i_cfg.sweep_pace}
                                               : SWEEP_DEFAULT_RELOAD;
    assign count_dec = (r_count != 4'd0) ? (r_count - 4'd1) : 4'd0;
    assign sweep_frame = i_item.frame_event && (i_item.frame_step[1:0] == SWEEP_FRAME_STEP);

    always_comb begin
        n_freq = r_freq;
        n_shadow = r_shadow;
        n_count = r_count;
        n_sweep_active = r_sweep_active;
        n_enabled = r_enabled;
        if (i_item.opcode) begin
            n_enabled = 1'b1;
            n_freq = i_cfg.frequency_setting;
            n_shadow = i_cfg.frequency_setting;
            n_count = reload;
            n_sweep_active = (i_cfg.sweep_pace != 3'd0) || (i_cfg.sweep_shift != 3'd0);
            if ((i_cfg.sweep_shift != 3'd0) && trig_calc[FREQ_W]) begin
                n_enabled = 1'b0;
            end
        end else if (sweep_frame) begin
            n_count = count_dec;
            if (count_dec == 4'd0) begin
                n_count = reload;
                if (r_sweep_active && (i_cfg.sweep_pace != 3'd0)) begin
                    if (step_calc[FREQ_W]) begin
                        n_enabled = 1'b0;
                    end else if (i_cfg.sweep_shift != 3'd0) begin
                        n_freq = step_calc[FREQ_W-1:0];
                        n_shadow = step_calc[FREQ_W-1:0];
                        if (check_calc[FREQ_W]) begin
                            n_enabled = 1'b0;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_freq <= '0;
            r_shadow <= '0;
            r_count <= '0;
            r_sweep_active <= 1'b0;
            r_enabled <= 1'b0;
        end else if (i_accept) begin
            r_freq <= n_freq;
            r_shadow <= n_shadow;
            r_count <= n_count;
            r_sweep_active <= n_sweep_active;
            r_enabled <= n_enabled;
        end
    end

    assign o_freq = r_freq;
    assign o_next_freq = n_freq;
    assign o_next_enabled = n_enabled;

endmodule

FILE: rtl/core/pcfs_tone.sv
// Period timer, duty sequencer and output level.
`timescale 1ns / 1ps

module pcfs_tone (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_accept,
    input  pcfs_pkg::t_in_item           i_item,
    input  pcfs_pkg::t_cfg               i_cfg,
    input  logic [pcfs_pkg::FREQ_W-1:0]  i_freq,
    output logic signed [4:0]            o_next_level
);
    import pcfs_pkg::*;

    logic [TIMER_W-1:0] r_timer, n_timer;
    logic [2:0]         r_duty, n_duty;
    logic [11:0]        span;
    logic [7:0]         pattern;
    logic               duty_bit;
    logic [4:0]         vol_ext;

    assign span = FREQ_SPAN - {1'b0, i_freq};

    always_comb begin
        n_timer = r_timer;
        n_duty = r_duty;
        if (!i_item.opcode) begin
            if (r_timer == '0) begin
                n_timer = {span, 2'b00};
                n_duty = r_duty + 3'd1;
            end else begin
                n_timer = r_timer - 14'd1;
            end
        end
    end

    assign pattern = DUTY_TABLE[i_cfg.duty_pattern];
    assign duty_bit = pattern[~n_duty];
    assign vol_ext = {1'b0, i_cfg.volume};
    assign o_next_level = !i_cfg.dac_enable ? 5'sd0
                        : (duty_bit ? $signed(vol_ext) : $signed(5'd0 - vol_ext));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timer <= '0;
            r_duty <= '0;
        end else if (i_accept) begin
            r_timer <= n_timer;
            r_duty <= n_duty;
        end
    end

endmodule
